### hw/rtl/motor_command_stepper_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Motor command stepper sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_STEPPER_SEQUENCER_ASSERT_SVH
`define MOTOR_COMMAND_STEPPER_SEQUENCER_ASSERT_SVH

// Same-cycle implication.
`define MCSS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mcss: same-cycle check failed");

// Next-cycle implication.
`define MCSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mcss: next-cycle check failed");

`endif

### hw/rtl/mcss_pkg.sv
// ----------------------------------------------------------------------------
// Motor command stepper sequencer package
// Operation format passed from the parser to the executor, and shared widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mcss_pkg;

	localparam int BYTE_W     = 8;
	localparam int DATA_W     = 16;
	localparam int OUT_TDATA_W = 40;  // 38 field bits padded to whole bytes

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// What the executor has to do with one transaction.
	typedef enum logic [1:0] {
		OP_NOP,   // byte that did not finish a packet
		OP_EXEC,  // escape byte: run the held command
		OP_TICK   // step timer tick
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [BYTE_W-1:0] cmd;
		logic [DATA_W-1:0] data;
	} op_t;

endpackage

`default_nettype wire

### hw/rtl/motor_command_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// Motor command stepper sequencer
// Serial packet parser, DC bridge control and half-step stepper sequencer.
// ----------------------------------------------------------------------------
// Each input transaction is a received serial byte (s_tuser[0] = 0) or a step
// timer tick (s_tuser[0] = 1) and yields exactly one output transaction that
// shows the coil, bridge, duty and interval levels after that item; m_tlast
// marks the escape byte that completed and executed a five-byte packet
// (0xFF start, command, data high, data low, escape). Throughput is one
// transaction per clock while m_tready stays high: the parser writes one
// operation per cycle into a two-entry queue and the executor retires one
// per cycle into the output register. An accepted item is written into the
// queue first and then moved by the executor into the output register.
// s_tready drops only when the queue holds two operations, which happens once
// m_tready has been low long enough to back the output register up. After
// reset the stepper is stopped, both bridge inputs are low, the duty is 32767
// and the step interval is 19999.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_command_stepper_sequencer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]                        s_tuser,   // [0] mode (1 = tick)
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [0] coil_a1, [1] coil_a2, [2] coil_b1, [3] coil_b2, [4] dc_in1,
	// [5] dc_in2, [21:6] dc_duty, [37:22] step_interval, [39:38] zero
	output logic [mcss_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                   m_tlast    // packet_done
);
	import mcss_pkg::*;

	logic q_full;
	logic push;
	op_t  push_op;
	logic pop;
	logic head_valid;
	op_t  head_op;

	// Parse bytes and classify each transaction.
	mcss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	// Decouple the parser from output stalls.
	mcss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// Execute operations on the motor state and present the result.
	mcss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/mcss_front.sv
// ----------------------------------------------------------------------------
// Motor command stepper sequencer front end
// Accepts bytes and ticks, parses five-byte packets and emits one operation
// per transaction into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [7:0]                s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0]                s_tuser,   // [0] mode
	input  wire logic                      q_full,
	output logic                           push,
	output mcss_pkg::op_t                  push_op
);
	import mcss_pkg::*;

	`include "motor_command_stepper_sequencer_assert.svh"

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_CMD  = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_LOW  = 3'd3;
	localparam logic [2:0] PH_ESC  = 3'd4;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] ESC_LOW    = 8'h02;
	localparam logic [BYTE_W-1:0] ESC_HIGH   = 8'h04;
	localparam logic [BYTE_W-1:0] ESC_BOTH   = 8'h06;

	logic [2:0]        parse_phase_q, parse_phase_d;
	logic [BYTE_W-1:0] cmd_q, high_q, low_q;
	logic [BYTE_W-1:0] high_d, low_d, cmd_d;
	logic              s_accept;
	logic              mode;
	logic [BYTE_W-1:0] rx_byte;

	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;
	assign mode     = s_tuser[0];
	assign rx_byte  = s_tdata;
	assign push     = s_accept;

	always_comb begin
		parse_phase_d = parse_phase_q;
		cmd_d         = cmd_q;
		high_d        = high_q;
		low_d         = low_q;
		push_op.kind  = OP_NOP;
		push_op.cmd   = cmd_q;
		push_op.data  = {high_q, low_q};
		if (mode) begin
			push_op.kind = OP_TICK;
		end else begin
			unique case (parse_phase_q)
				PH_CMD: begin
					cmd_d         = rx_byte;
					parse_phase_d = PH_HIGH;
				end
				PH_HIGH: begin
					high_d        = rx_byte;
					parse_phase_d = PH_LOW;
				end
				PH_LOW: begin
					low_d         = rx_byte;
					parse_phase_d = PH_ESC;
				end
				PH_ESC: begin
					// apply the escape before forming the data word
					if (rx_byte == ESC_LOW || rx_byte == ESC_BOTH) begin
						low_d = 8'hFF;
					end
					if (rx_byte == ESC_HIGH || rx_byte == ESC_BOTH) begin
						high_d = 8'hFF;
					end
					parse_phase_d = PH_IDLE;
					push_op.kind  = OP_EXEC;
					push_op.data  = {high_d, low_d};
				end
				default: begin
					// waiting for start; stray phase codes behave the same
					parse_phase_d = (rx_byte == START_BYTE) ? PH_CMD : PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase_q <= PH_IDLE;
			cmd_q         <= '0;
			high_q        <= '0;
			low_q         <= '0;
		end else if (s_accept) begin
			parse_phase_q <= parse_phase_d;
			cmd_q         <= cmd_d;
			high_q        <= high_d;
			low_q         <= low_d;
		end
	end

	`MCSS_ASSERT_IMP(a_exec_only_at_escape, push && (push_op.kind == OP_EXEC), parse_phase_q == PH_ESC)
	`MCSS_ASSERT_NEXT(a_escape_returns_idle, s_accept && !mode && (parse_phase_q == PH_ESC), parse_phase_q == PH_IDLE)

endmodule

`default_nettype wire

### hw/rtl/mcss_queue.sv
// ----------------------------------------------------------------------------
// Motor command stepper sequencer operation queue
// Short FIFO between parser and executor so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  mcss_pkg::op_t      push_op,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output mcss_pkg::op_t      head_op
);
	import mcss_pkg::*;

	`include "motor_command_stepper_sequencer_assert.svh"

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`MCSS_ASSERT_IMP(a_no_push_when_full, push, !full)
	`MCSS_ASSERT_IMP(a_no_pop_when_empty, pop, head_valid)

endmodule

`default_nettype wire

### hw/rtl/mcss_back.sv
// ----------------------------------------------------------------------------
// Motor command stepper sequencer back end
// Executes queued operations on the motor state and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_back (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            head_valid,
	input  mcss_pkg::op_t                        head_op,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [mcss_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast
);
	import mcss_pkg::*;

	`include "motor_command_stepper_sequencer_assert.svh"

	localparam logic [2:0] SM_STOP      = 3'd0;
	localparam logic [2:0] SM_CONT_FWD  = 3'd2;
	localparam logic [2:0] SM_CONT_BACK = 3'd3;
	localparam logic [2:0] SM_HOLD      = 3'd6;

	localparam logic [BYTE_W-1:0] CMD_DC_STOP   = 8'h00;
	localparam logic [BYTE_W-1:0] CMD_DC_FWD    = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_DC_REV    = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_STEP_STOP = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_STEP_FWD  = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_STEP_BACK = 8'h05;
	localparam logic [BYTE_W-1:0] CMD_RUN_FWD   = 8'h06;
	localparam logic [BYTE_W-1:0] CMD_RUN_BACK  = 8'h07;
	localparam logic [BYTE_W-1:0] CMD_HOLD      = 8'h08;

	localparam logic [DATA_W-1:0] DUTY_RESET     = 16'd32767;
	localparam logic [DATA_W-1:0] INTERVAL_RESET = 16'd19999;

	// Half-step table, coils as {b2, b1, a2, a1}.
	function automatic logic [3:0] coil_pattern(input logic [2:0] p);
		logic [3:0] c;
		unique case (p)
			3'd0:    c = 4'b0001;
			3'd1:    c = 4'b0011;
			3'd2:    c = 4'b0010;
			3'd3:    c = 4'b0110;
			3'd4:    c = 4'b0100;
			3'd5:    c = 4'b1100;
			3'd6:    c = 4'b1000;
			default: c = 4'b1001;
		endcase
		coil_pattern = c;
	endfunction

	logic [2:0]        mode_q, mode_d;
	logic [2:0]        phase_q, phase_d;
	logic [3:0]        coil_q, coil_d;
	logic [1:0]        dc_q, dc_d;
	logic [DATA_W-1:0] duty_q, duty_d;
	logic [DATA_W-1:0] interval_q, interval_d;
	logic              tvalid_q, tlast_q;
	logic [OUT_TDATA_W-1:0] tdata_q;

	assign pop      = head_valid && (!tvalid_q || m_tready);
	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		coil_d     = coil_q;
		dc_d       = dc_q;
		duty_d     = duty_q;
		interval_d = interval_q;
		unique case (head_op.kind)
			OP_TICK: begin
				unique case (mode_q)
					SM_STOP: coil_d = 4'b0000;
					SM_CONT_FWD: begin
						phase_d = phase_q + 3'd1;
						coil_d  = coil_pattern(phase_d);
					end
					SM_CONT_BACK: begin
						phase_d = phase_q - 3'd1;
						coil_d  = coil_pattern(phase_d);
					end
					SM_HOLD: coil_d = coil_pattern(phase_q);
					default: coil_d = coil_q;  // unused modes: no change
				endcase
			end
			OP_EXEC: begin
				unique case (head_op.cmd)
					CMD_DC_STOP: dc_d = 2'b00;
					CMD_DC_FWD: begin
						duty_d = head_op.data;
						dc_d   = 2'b01;
					end
					CMD_DC_REV: begin
						duty_d = head_op.data;
						dc_d   = 2'b10;
					end
					CMD_STEP_STOP: begin
						mode_d = SM_STOP;
						coil_d = 4'b0000;
					end
					CMD_STEP_FWD: begin
						mode_d  = SM_HOLD;
						phase_d = phase_q + 3'd1;
						coil_d  = coil_pattern(phase_d);
					end
					CMD_STEP_BACK: begin
						mode_d  = SM_HOLD;
						phase_d = phase_q - 3'd1;
						coil_d  = coil_pattern(phase_d);
					end
					CMD_RUN_FWD: begin
						interval_d = head_op.data;
						mode_d     = SM_CONT_FWD;
					end
					CMD_RUN_BACK: begin
						interval_d = head_op.data;
						mode_d     = SM_CONT_BACK;
					end
					CMD_HOLD: mode_d = SM_HOLD;
					default:  mode_d = mode_q;  // unknown command: ignore
				endcase
			end
			default: mode_d = mode_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= SM_STOP;
			phase_q    <= '0;
			coil_q     <= '0;
			dc_q       <= '0;
			duty_q     <= DUTY_RESET;
			interval_q <= INTERVAL_RESET;
			tvalid_q   <= 1'b0;
		end else begin
			if (pop) begin
				mode_q     <= mode_d;
				phase_q    <= phase_d;
				coil_q     <= coil_d;
				dc_q       <= dc_d;
				duty_q     <= duty_d;
				interval_q <= interval_d;
				tvalid_q   <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= {2'b00, interval_d, duty_d, dc_d, coil_d};
			tlast_q <= (head_op.kind == OP_EXEC);
		end
	end

	`MCSS_ASSERT_NEXT(a_stop_tick_clears, pop && (head_op.kind == OP_TICK) && (mode_q == SM_STOP), tdata_q[3:0] == 4'b0000)

endmodule

`default_nettype wire

### test/motor_command_stepper_sequencer_test.sv
// ----------------------------------------------------------------------------
// Motor command stepper sequencer testbench
// Streams serial bytes and step ticks into the sequencer, predicts the coil,
// bridge, duty and interval levels after each item and checks every result
// transaction against that prediction, under random gaps and back pressure.
// ----------------------------------------------------------------------------
module motor_command_stepper_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mcss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	// Packet framing and escape codes.
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] ESC_LOW    = 8'h02;
	localparam logic [7:0] ESC_HIGH   = 8'h04;
	localparam logic [7:0] ESC_BOTH   = 8'h06;

	// Command codes.
	localparam logic [7:0] CMD_DC_STOP   = 8'h00;
	localparam logic [7:0] CMD_DC_FWD    = 8'h01;
	localparam logic [7:0] CMD_DC_REV    = 8'h02;
	localparam logic [7:0] CMD_STEP_STOP = 8'h03;
	localparam logic [7:0] CMD_STEP_NEXT = 8'h04;
	localparam logic [7:0] CMD_STEP_PREV = 8'h05;
	localparam logic [7:0] CMD_RUN_FWD   = 8'h06;
	localparam logic [7:0] CMD_RUN_BACK  = 8'h07;
	localparam logic [7:0] CMD_STEP_HOLD = 8'h08;
	localparam logic [7:0] CMD_LAST      = CMD_STEP_HOLD;

	// Input kinds carried on s_tuser.
	localparam bit KIND_BYTE = 1'b0;
	localparam bit KIND_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CMD,
		PH_HIGH,
		PH_LOW,
		PH_ESC
	} parse_phase_e;

	typedef enum logic [2:0] {
		STEP_STOP = 3'd0,
		STEP_FWD  = 3'd2,
		STEP_BACK = 3'd3,
		STEP_HOLD = 3'd6
	} stepper_mode_e;

	// Levels after one item; coils are {b2, b1, a2, a1}, bridge is {in2, in1}.
	typedef struct packed {
		logic [3:0]  coils;
		logic [1:0]  bridge;
		logic [15:0] duty;
		logic [15:0] interval;
		logic        done;
	} motor_levels_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // [7:0] rx_byte
	logic [0:0]             s_tuser;   // [0] mode (1 = tick)
	logic                   m_tvalid;
	logic                   m_tready;
	// [0] coil_a1, [1] coil_a2, [2] coil_b1, [3] coil_b2, [4] dc_in1,
	// [5] dc_in2, [21:6] dc_duty, [37:22] step_interval, [39:38] zero
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;   // packet_done

	// Predicted sequencer state.
	parse_phase_e  parse_now;
	logic [7:0]    cmd_held;
	logic [7:0]    high_held;
	logic [7:0]    low_held;
	stepper_mode_e run_mode;
	logic [2:0]    step_idx;
	logic [3:0]    coils_now;
	logic [1:0]    bridge_now;
	logic [15:0]   duty_now;
	logic [15:0]   interval_now;

	motor_levels_t levels_due[$];
	int            mismatch_count = 0;
	int            items_sent = 0;
	int            cycle_count = 0;
	bit            traffic_gaps = 1'b1;  // random idling on both sides
	int            stall_cycles = 0;     // requested receiver hold-off

	motor_command_stepper_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Coil pattern of one half-step phase, {b2, b1, a2, a1}.
	function automatic logic [3:0] half_step(input logic [2:0] idx);
		case (idx)
			3'd0: half_step = 4'b0001;
			3'd1: half_step = 4'b0011;
			3'd2: half_step = 4'b0010;
			3'd3: half_step = 4'b0110;
			3'd4: half_step = 4'b0100;
			3'd5: half_step = 4'b1100;
			3'd6: half_step = 4'b1000;
			default: half_step = 4'b1001;
		endcase
	endfunction

	task automatic clear_levels();
		parse_now = PH_IDLE;
		cmd_held = '0;
		high_held = '0;
		low_held = '0;
		run_mode = STEP_STOP;
		step_idx = '0;
		coils_now = '0;
		bridge_now = '0;
		duty_now = 16'd32767;
		interval_now = 16'd19999;
	endtask

	// Execute the held command with the escaped data word.
	task automatic run_packet(input logic [15:0] word);
		case (cmd_held)
			CMD_DC_STOP: bridge_now = 2'b00;
			CMD_DC_FWD: begin
				duty_now = word;
				bridge_now = 2'b01;
			end
			CMD_DC_REV: begin
				duty_now = word;
				bridge_now = 2'b10;
			end
			CMD_STEP_STOP: begin
				run_mode = STEP_STOP;
				coils_now = '0;
			end
			CMD_STEP_NEXT: begin
				run_mode = STEP_HOLD;
				step_idx = step_idx + 3'd1;
				coils_now = half_step(step_idx);
			end
			CMD_STEP_PREV: begin
				run_mode = STEP_HOLD;
				step_idx = step_idx - 3'd1;
				coils_now = half_step(step_idx);
			end
			CMD_RUN_FWD: begin
				interval_now = word;
				run_mode = STEP_FWD;
			end
			CMD_RUN_BACK: begin
				interval_now = word;
				run_mode = STEP_BACK;
			end
			CMD_STEP_HOLD: run_mode = STEP_HOLD;
			default: ;  // unknown command: ignore, still completes the packet
		endcase
	endtask

	// Advance the predicted state by one accepted item and queue its levels.
	task automatic predict_levels(input bit tick, input logic [7:0] rx);
		motor_levels_t lv;
		logic          done;
		done = 1'b0;
		if (tick) begin
			case (run_mode)
				STEP_STOP: coils_now = '0;
				STEP_FWD: begin
					step_idx = step_idx + 3'd1;
					coils_now = half_step(step_idx);
				end
				STEP_BACK: begin
					step_idx = step_idx - 3'd1;
					coils_now = half_step(step_idx);
				end
				STEP_HOLD: coils_now = half_step(step_idx);
				default: ;
			endcase
		end else begin
			case (parse_now)
				PH_CMD: begin
					cmd_held = rx;
					parse_now = PH_HIGH;
				end
				PH_HIGH: begin
					high_held = rx;
					parse_now = PH_LOW;
				end
				PH_LOW: begin
					low_held = rx;
					parse_now = PH_ESC;
				end
				PH_ESC: begin
					parse_now = PH_IDLE;
					if (rx == ESC_LOW)
						low_held = 8'hFF;
					else if (rx == ESC_HIGH)
						high_held = 8'hFF;
					else if (rx == ESC_BOTH) begin
						low_held = 8'hFF;
						high_held = 8'hFF;
					end
					run_packet({high_held, low_held});
					done = 1'b1;
				end
				// a start byte anywhere else in a packet is plain content
				default: parse_now = (rx == START_BYTE) ? PH_CMD : PH_IDLE;
			endcase
		end
		lv.coils = coils_now;
		lv.bridge = bridge_now;
		lv.duty = duty_now;
		lv.interval = interval_now;
		lv.done = done;
		levels_due.push_back(lv);
	endtask

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
			cycle_count, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin : result_check
		motor_levels_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (levels_due.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[31:0], 0);
			end else begin
				want = levels_due.pop_front();
				check_field("coil_a1", 32'(m_tdata[0]), 32'(want.coils[0]));
				check_field("coil_a2", 32'(m_tdata[1]), 32'(want.coils[1]));
				check_field("coil_b1", 32'(m_tdata[2]), 32'(want.coils[2]));
				check_field("coil_b2", 32'(m_tdata[3]), 32'(want.coils[3]));
				check_field("dc_in1", 32'(m_tdata[4]), 32'(want.bridge[0]));
				check_field("dc_in2", 32'(m_tdata[5]), 32'(want.bridge[1]));
				check_field("dc_duty", 32'(m_tdata[21:6]), 32'(want.duty));
				check_field("step_interval", 32'(m_tdata[37:22]),
					32'(want.interval));
				check_field("tdata padding", 32'(m_tdata[39:38]), 0);
				check_field("packet_done", 32'(m_tlast), 32'(want.done));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Traffic
	// ------------------------------------------------------------------------

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!traffic_gaps || r < 60)
			pick_gap = 0;
		else if (r < 92)
			pick_gap = $urandom_range(1, 3);
		else
			pick_gap = $urandom_range(4, 30);
	endfunction

	// Byte values leaning toward the extremes.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			pick_byte = 8'h00;
		else if (r == 1)
			pick_byte = 8'hFF;
		else
			pick_byte = 8'($urandom_range(0, 255));
	endfunction

	// Receiver: ready with random holds, plus long hold-offs on request.
	initial begin
		m_tready = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (stall_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (stall_cycles) @(posedge clk);
				stall_cycles = 0;
			end else if (!traffic_gaps || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// Offer one item, hold it until accepted, then predict its result.
	task automatic send_item(input bit tick, input logic [7:0] rx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= tick;
		s_tdata <= tick ? 8'($urandom_range(0, 255)) : rx;
		do
			@(posedge clk);
		while (!s_tready);
		predict_levels(tick, rx);
		items_sent++;
	endtask

	// Send a five-byte packet, sometimes with ticks slipped in between bytes.
	task automatic send_packet(input logic [7:0] cmd, input logic [7:0] hi,
			input logic [7:0] lo, input logic [7:0] esc, input bit mix_ticks);
		logic [7:0] pkt [5];
		pkt[0] = START_BYTE;
		pkt[1] = cmd;
		pkt[2] = hi;
		pkt[3] = lo;
		pkt[4] = esc;
		for (int i = 0; i < 5; i++) begin
			if (mix_ticks && $urandom_range(0, 9) == 0)
				send_item(KIND_TICK, 8'h00);
			send_item(KIND_BYTE, pkt[i]);
		end
	endtask

	// Well-formed packet with random content, mostly known commands.
	task automatic send_random_packet();
		logic [7:0] cmd;
		logic [7:0] esc;
		int         r;
		cmd = ($urandom_range(0, 9) == 0) ? pick_byte() : 8'($urandom_range(0, CMD_LAST));
		r = $urandom_range(0, 4);
		case (r)
			0: esc = ESC_LOW;
			1: esc = ESC_HIGH;
			2: esc = ESC_BOTH;
			default: esc = pick_byte();
		endcase
		send_packet(cmd, pick_byte(), pick_byte(), esc, 1'b1);
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (levels_due.size() != 0);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// A stray byte while waiting for a start byte, and a tick while stopped.
	task automatic test_idle_traffic();
		send_item(KIND_BYTE, 8'h00);
		send_item(KIND_TICK, 8'h00);
	endtask

	// Each escape form, and an escape byte that changes nothing.
	task automatic test_escape_forms();
		send_packet(CMD_DC_FWD, 8'h00, 8'h00, ESC_LOW, 1'b0);
		send_packet(CMD_DC_REV, 8'hAB, 8'hCD, ESC_HIGH, 1'b0);
		send_packet(CMD_DC_FWD, 8'h12, 8'h34, ESC_BOTH, 1'b0);
		send_packet(CMD_RUN_BACK, 8'h00, 8'h00, 8'h55, 1'b0);
		// retreat from phase zero wraps to the top of the table
		send_item(KIND_TICK, 8'h00);
		send_item(KIND_TICK, 8'h00);
	endtask

	// Start bytes inside a packet are content; command 0xFF is unknown.
	task automatic test_start_in_packet();
		send_packet(START_BYTE, START_BYTE, START_BYTE, START_BYTE, 1'b0);
	endtask

	// Mostly packets with random content, plus tick bursts, noise and
	// truncated packets that knock the framing out of step.
	task automatic test_random_traffic(input int count);
		int stop_at;
		int r;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 39) == 0)
				traffic_gaps = !traffic_gaps;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				send_random_packet();
			end else if (r < 85) begin
				repeat ($urandom_range(1, 8)) send_item(KIND_TICK, 8'h00);
			end else if (r < 95) begin
				repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, pick_byte());
			end else begin
				send_item(KIND_BYTE, START_BYTE);
				repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, pick_byte());
			end
		end
		traffic_gaps = 1'b1;
	endtask

	// Hold the result side off while items keep coming, so the input stalls.
	task automatic test_output_stall();
		traffic_gaps = 1'b0;
		stall_cycles = 300;
		repeat (12) send_random_packet();
		traffic_gaps = 1'b1;
	endtask

	// Let the block run dry between two back-to-back bursts.
	task automatic test_sender_pause();
		traffic_gaps = 1'b0;
		send_packet(CMD_RUN_FWD, 8'h00, 8'h10, 8'h00, 1'b0);
		repeat (10) send_item(KIND_TICK, 8'h00);
		wait_drained();
		send_packet(CMD_STEP_PREV, 8'h00, 8'h00, 8'h00, 1'b0);
		send_packet(CMD_STEP_HOLD, 8'h00, 8'h00, 8'h00, 1'b0);
		repeat (4) send_item(KIND_TICK, 8'h00);
		send_packet(CMD_STEP_STOP, 8'h00, 8'h00, 8'h00, 1'b0);
		send_packet(CMD_DC_STOP, 8'h00, 8'h00, 8'h00, 1'b0);
		send_item(KIND_TICK, 8'h00);
		traffic_gaps = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		clear_levels();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_traffic();
		test_escape_forms();
		test_start_in_packet();
		test_random_traffic(1350);
		test_output_stall();
		test_sender_pause();
		test_random_traffic(60);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mcss_pkg.sv
hw/rtl/mcss_front.sv
hw/rtl/mcss_queue.sv
hw/rtl/mcss_back.sv
hw/rtl/motor_command_stepper_sequencer.sv
test/motor_command_stepper_sequencer_test.sv
